// ----- rtl/pmq_pkg.sv -----
package pmq_pkg;

  // Handle width is fixed by the payload fields
  localparam int HANDLE_BITS = 32;
  // Number of cap registers; queues beyond these have no cap
  localparam int NUM_CAPS = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 5;

  // Register indexes on the write port
  localparam logic [CFG_INDEX_BITS-1:0] REG_OPEN = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CAP0 = 3'd1;

  typedef enum logic {
    OP_SEND = 1'b0,
    OP_RECV = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_CLOSED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    op_t                    operation;
    logic [HANDLE_BITS-1:0] message_handle;
    logic [2:0]             priority_req;
  } pmq_cmd_t;

  typedef struct packed {
    status_t                status;
    logic [HANDLE_BITS-1:0] handle_out;
    logic [1:0]             queue_index;
    logic [4:0]             queue_count;
    logic [6:0]             total_count;
    logic                   pending;
  } pmq_rsp_t;

endpackage

// ----- rtl/priority_mailbox_queues.sv -----
// The result of an operation is strobed on done in the cycle after it is accepted.
// Throughput: one send or receive per cycle; busy stays low, each operation makes at most one
// store write or one store read, done through a single registered memory port pair.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Reset (synchronous): pointers and counts cleared, mailbox closed, caps zero; the
// message store is not cleared, only written entries are ever read.
module priority_mailbox_queues #(
  parameter int LEVELS      = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  pmq_pkg::pmq_cmd_t                   cmd,
  output logic                                done,
  output pmq_pkg::pmq_rsp_t                   result,
  input  logic                                cfg_we,
  input  logic [pmq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pmq_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import pmq_pkg::*;

  localparam int STORE_SIZE = LEVELS * QUEUE_DEPTH;
  localparam int AW   = $clog2(STORE_SIZE);
  localparam int QW   = $clog2(LEVELS);
  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int TW   = $clog2(STORE_SIZE + 1);
  localparam int CMPW = (CW > CFG_DATA_BITS) ? CW : CFG_DATA_BITS;

  // Configuration registers
  logic                     open;
  logic [CFG_DATA_BITS-1:0] caps [NUM_CAPS];

  // Queue state
  logic [PW-1:0] heads [LEVELS];
  logic [PW-1:0] tails [LEVELS];
  logic [CW-1:0] counts [LEVELS];
  logic [TW-1:0] total;
  logic [PW-1:0] heads_next [LEVELS];
  logic [PW-1:0] tails_next [LEVELS];
  logic [CW-1:0] counts_next [LEVELS];
  logic [TW-1:0] total_next;

  // Message store
  logic [HANDLE_BITS-1:0] store [STORE_SIZE];
  logic [HANDLE_BITS-1:0] rd_data;

  // Result registers
  status_t       res_status;
  logic [QW-1:0] res_queue;
  logic [CW-1:0] res_count;
  logic [TW-1:0] res_total;
  logic          res_pop;

  // Decode outputs
  logic          accept;
  status_t       status_c;
  logic [QW-1:0] queue_c;
  logic          wr_en;
  logic          pop;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  // Every cycle takes a new operation
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Decode one operation against the current queue state
  always_comb begin
    logic                     found;
    logic [QW-1:0]            sel_q;
    logic [QW-1:0]            send_q;
    logic [CFG_DATA_BITS-1:0] cap;
    logic                     bad_prio;
    logic                     at_limit;
    found    = 1'b0;
    sel_q    = '0;
    cap      = '0;
    heads_next  = heads;
    tails_next  = tails;
    counts_next = counts;
    total_next  = total;
    status_c = ST_OK;
    queue_c  = '0;
    wr_en    = 1'b0;
    pop      = 1'b0;
    // lowest-numbered non-empty queue
    for (int i = 0; i < LEVELS; i++) begin
      if (!found && counts[i] != '0) begin
        found = 1'b1;
        sel_q = QW'(i);
      end
    end
    send_q   = QW'(LEVELS - int'(cmd.priority_req));
    bad_prio = (cmd.priority_req == 3'd0) || (int'(cmd.priority_req) > LEVELS);
    for (int j = 0; j < NUM_CAPS; j++) begin
      if (int'(send_q) == j) cap = caps[j];
    end
    at_limit = 1'b0;
    if (!open) begin
      status_c = ST_CLOSED;
    end else if (cmd.operation == OP_SEND) begin
      if (bad_prio) begin
        status_c = ST_FULL;
      end else begin
        queue_c  = send_q;
        at_limit = (cap != '0 && CMPW'(counts[send_q]) >= CMPW'(cap)) ||
                   (counts[send_q] >= CW'(QUEUE_DEPTH));
        if (at_limit) begin
          status_c = ST_FULL;
        end else begin
          wr_en = 1'b1;
          tails_next[send_q]  = advance(tails[send_q]);
          counts_next[send_q] = counts[send_q] + 1'b1;
          total_next          = total + 1'b1;
        end
      end
    end else if (found) begin
      queue_c = sel_q;
      pop     = 1'b1;
      heads_next[sel_q]  = advance(heads[sel_q]);
      counts_next[sel_q] = counts[sel_q] - 1'b1;
      total_next         = total - 1'b1;
    end else begin
      status_c = ST_EMPTY;
    end
  end

  // Store addresses: queue base plus pointer
  assign wr_addr = AW'(queue_c) * AW'(QUEUE_DEPTH) + AW'(tails[queue_c]);
  assign rd_addr = AW'(queue_c) * AW'(QUEUE_DEPTH) + AW'(heads[queue_c]);

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (accept && wr_en) store[wr_addr] <= cmd.message_handle;
    if (accept && pop) rd_data <= store[rd_addr];
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      open  <= 1'b0;
      done  <= 1'b0;
      total <= '0;
      for (int j = 0; j < NUM_CAPS; j++) caps[j] <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OPEN) begin
          open <= cfg_data[0];
        end else if (cfg_index >= REG_CAP0 &&
                     int'(cfg_index) < int'(REG_CAP0) + NUM_CAPS) begin
          for (int j = 0; j < NUM_CAPS; j++) begin
            if (int'(cfg_index) - int'(REG_CAP0) == j) caps[j] <= cfg_data;
          end
        end
      end
      done <= accept;
      if (accept) begin
        heads  <= heads_next;
        tails  <= tails_next;
        counts <= counts_next;
        total  <= total_next;
      end
    end
  end

  // Result beat registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status_c;
      res_queue  <= queue_c;
      res_count  <= (status_c == ST_OK || (status_c == ST_FULL && !(cmd.priority_req == 3'd0 ||
                    int'(cmd.priority_req) > LEVELS))) ? counts_next[queue_c] : '0;
      res_total  <= total_next;
      res_pop    <= pop;
    end
  end

  assign result.status      = res_status;
  assign result.handle_out  = res_pop ? rd_data : '0;
  assign result.queue_index = 2'(res_queue);
  assign result.queue_count = 5'(res_count);
  assign result.total_count = 7'(res_total);
  assign result.pending     = (res_total != '0);

  // Every accepted operation yields one beat in the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && !rst) |=> done) else $error("missing result beat");

  // Total never exceeds the store size
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    int'(total) <= STORE_SIZE) else $error("total count overflow");

  // A stored send grows the total by exactly one
  a_send_incr: assert property (@(posedge clk) disable iff (rst)
    (accept && wr_en) |=> (total == $past(total) + 1'b1)) else $error("send count slip");

  // Empty report only when nothing is held
  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_EMPTY) |-> (res_total == '0 && !result.pending))
    else $error("empty reported with messages held");

endmodule
